@@ rtl/usw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package usw_pkg;

  localparam int MAX_DIM     = 256;
  localparam int MIN_DIM     = 2;
  localparam int CNT_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = CNT_W + 1;
  localparam int FLUX_W      = 32;
  localparam int SPACE_W     = 32;
  localparam int IDX_W       = 16;
  localparam int COEFF_W     = 48;
  localparam int PROD_W      = FLUX_W + SPACE_W;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(MAX_DIM);
  localparam logic [SPACE_W-1:0] SPACE_RESET = SPACE_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = CFG_IDX_W'(0),
    REG_GRID_HEIGHT = CFG_IDX_W'(1),
    REG_SPACING_X   = CFG_IDX_W'(2),
    REG_SPACING_Y   = CFG_IDX_W'(3)
  } usw_reg_t;

  // One classified cell: its linear row index, the four neighbor columns and
  // the six face magnitudes that the back end multiplies.
  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col_xp;
    logic [IDX_W-1:0]  col_xm;
    logic [IDX_W-1:0]  col_yp;
    logic [IDX_W-1:0]  col_yn;
    logic [FLUX_W-1:0] mag_dx;
    logic [FLUX_W-1:0] mag_dy;
    logic [FLUX_W-1:0] mag_xp;
    logic [FLUX_W-1:0] mag_xm;
    logic [FLUX_W-1:0] mag_yp;
    logic [FLUX_W-1:0] mag_yn;
  } usw_cell_t;

  typedef struct packed {
    logic full;
    logic empty;
  } usw_qstat_t;

endpackage

`default_nettype wire

@@ rtl/usw_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface usw_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [usw_pkg::FLUX_W-1:0] flux_x_plus;
  logic signed [usw_pkg::FLUX_W-1:0] flux_y_plus;
  logic signed [usw_pkg::FLUX_W-1:0] flux_x_minus;
  logic signed [usw_pkg::FLUX_W-1:0] flux_y_minus;

  modport source (output valid, flux_x_plus, flux_y_plus, flux_x_minus, flux_y_minus,
                  input ready);
  modport sink (input valid, flux_x_plus, flux_y_plus, flux_x_minus, flux_y_minus,
                output ready);
endinterface

interface usw_out_if;
  logic                               valid;
  logic                               ready;
  logic        [usw_pkg::IDX_W-1:0]   row_index;
  logic        [usw_pkg::IDX_W-1:0]   col_index;
  logic signed [usw_pkg::COEFF_W-1:0] coeff_value;
  logic                               last_entry;

  modport source (output valid, row_index, col_index, coeff_value, last_entry,
                  input ready);
  modport sink (input valid, row_index, col_index, coeff_value, last_entry,
                output ready);
endinterface

interface usw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [usw_pkg::CFG_IDX_W-1:0]     index;
  logic [usw_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/usw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usw_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  usw_in_if.sink                              in_chan,
  input  wire logic [usw_pkg::DIM_W-1:0]      grid_width,
  input  wire logic [usw_pkg::DIM_W-1:0]      grid_height,
  input  wire usw_pkg::usw_qstat_t            q_stat,
  output logic                                push,
  output usw_pkg::usw_cell_t                  push_cell
);

  localparam int CW = usw_pkg::CNT_W;
  localparam int DW = usw_pkg::DIM_W;
  localparam int IW = usw_pkg::IDX_W;
  localparam int FW = usw_pkg::FLUX_W;
  localparam int MW = CW + DW;

  logic [CW-1:0] cell_x_r, cell_x_nxt;
  logic [CW-1:0] cell_y_r, cell_y_nxt;

  logic [DW-1:0] w, h, w_m1, h_m1;
  logic [CW-1:0] x, y, xp, xn, yp, yn;
  logic [MW-1:0] yw, ypw, ynw;
  logic [FW-1:0] pos_xp, neg_xp, pos_xm, neg_xm;
  logic [FW-1:0] pos_yp, neg_yp, pos_ym, neg_ym;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    if (v < DW'(usw_pkg::MIN_DIM))      r = DW'(usw_pkg::MIN_DIM);
    else if (v > DW'(usw_pkg::MAX_DIM)) r = DW'(usw_pkg::MAX_DIM);
    else                                r = v;
    return r;
  endfunction

  function automatic logic [FW-1:0] pos_part(input logic [FW-1:0] g);
    return g[FW-1] ? '0 : g;
  endfunction

  // The negation of the most negative value is its own bit pattern, read as unsigned.
  function automatic logic [FW-1:0] neg_part(input logic [FW-1:0] g);
    return g[FW-1] ? (~g + FW'(1)) : '0;
  endfunction

  assign in_chan.ready = !q_stat.full;
  assign push          = in_chan.valid && in_chan.ready;

  always_comb begin
    w    = clamp_dim(grid_width);
    h    = clamp_dim(grid_height);
    w_m1 = w - DW'(1);
    h_m1 = h - DW'(1);

    // A counter left beyond a grid that has since shrunk restarts at zero.
    x = ({1'b0, cell_x_r} >= w) ? '0 : cell_x_r;
    y = ({1'b0, cell_y_r} >= h) ? '0 : cell_y_r;

    xp = ({1'b0, x} == w_m1) ? '0 : x + CW'(1);
    xn = (x == '0) ? w_m1[CW-1:0] : x - CW'(1);
    yp = ({1'b0, y} == h_m1) ? '0 : y + CW'(1);
    yn = (y == '0) ? h_m1[CW-1:0] : y - CW'(1);

    yw  = MW'(y)  * MW'(w);
    ypw = MW'(yp) * MW'(w);
    ynw = MW'(yn) * MW'(w);

    pos_xp = pos_part(in_chan.flux_x_plus);
    neg_xp = neg_part(in_chan.flux_x_plus);
    pos_xm = pos_part(in_chan.flux_x_minus);
    neg_xm = neg_part(in_chan.flux_x_minus);
    pos_yp = pos_part(in_chan.flux_y_plus);
    neg_yp = neg_part(in_chan.flux_y_plus);
    pos_ym = pos_part(in_chan.flux_y_minus);
    neg_ym = neg_part(in_chan.flux_y_minus);

    push_cell.row    = yw[IW-1:0]  + IW'(x);
    push_cell.col_xp = yw[IW-1:0]  + IW'(xp);
    push_cell.col_xm = yw[IW-1:0]  + IW'(xn);
    push_cell.col_yp = ypw[IW-1:0] + IW'(x);
    push_cell.col_yn = ynw[IW-1:0] + IW'(x);
    push_cell.mag_dx = pos_xp + neg_xm;
    push_cell.mag_dy = pos_yp + neg_ym;
    push_cell.mag_xp = neg_xp;
    push_cell.mag_xm = pos_xm;
    push_cell.mag_yp = neg_yp;
    push_cell.mag_yn = pos_ym;

    cell_x_nxt = xp;
    cell_y_nxt = ({1'b0, x} == w_m1) ? yp : y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_x_r <= '0;
      cell_y_r <= '0;
    end else if (push) begin
      cell_x_r <= cell_x_nxt;
      cell_y_r <= cell_y_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/usw_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usw_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire usw_pkg::usw_cell_t  push_cell,
  input  wire logic                pop,
  output usw_pkg::usw_cell_t       head_cell,
  output usw_pkg::usw_qstat_t      q_stat
);

  localparam int PW = usw_pkg::QPTR_W;
  localparam int CW = usw_pkg::QCNT_W;
  localparam int DEPTH = usw_pkg::QUEUE_DEPTH;

  usw_pkg::usw_cell_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head_cell    = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/usw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usw_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire usw_pkg::usw_cell_t            head_cell,
  input  wire usw_pkg::usw_qstat_t           q_stat,
  input  wire logic [usw_pkg::SPACE_W-1:0]   spacing_x,
  input  wire logic [usw_pkg::SPACE_W-1:0]   spacing_y,
  output logic                               pop,
  usw_out_if.source                          out_chan
);

  localparam int IW = usw_pkg::IDX_W;
  localparam int FW = usw_pkg::FLUX_W;
  localparam int SW = usw_pkg::SPACE_W;
  localparam int PW = usw_pkg::PROD_W;
  localparam int KW = usw_pkg::COEFF_W;
  localparam int RW = PW - usw_pkg::FRAC_W;
  localparam int VW = RW + 2;
  localparam logic [PW-1:0] HALF = PW'(1) << (usw_pkg::FRAC_W - 1);
  localparam logic signed [VW-1:0] SAT_HI = (VW'(1) <<< (KW - 1)) - VW'(1);
  localparam logic signed [VW-1:0] SAT_LO = -(VW'(1) <<< (KW - 1));

  typedef enum logic [2:0] {ENT_DIAG, ENT_XP, ENT_XM, ENT_YP, ENT_YN} ent_t;

  ent_t ent_r, ent_nxt;

  logic          s1_v_r;
  logic [PW-1:0] prod_a_r, prod_b_r;
  logic          s1_neg_r, s1_last_r;
  logic [IW-1:0] s1_row_r, s1_col_r;

  logic          out_v_r;
  logic [IW-1:0] out_row_r, out_col_r;
  logic [KW-1:0] out_coeff_r;
  logic          out_last_r;

  logic          out_adv, s1_load, issue;
  logic [FW-1:0] mag_a, mag_b;
  logic [SW-1:0] h_a;
  logic [IW-1:0] col_sel;
  logic [PW-1:0] prod_a, prod_b;

  logic [PW-1:0]          rnd_a, rnd_b;
  logic [RW:0]            sum_ab;
  logic signed [VW-1:0]   val;
  logic [KW-1:0]          coeff_sat;

  assign out_adv = !out_v_r || out_chan.ready;
  assign s1_load = !s1_v_r || out_adv;
  assign issue   = s1_load && !q_stat.empty;
  assign pop     = issue && (ent_r == ENT_YN);

  // Entry selection: the diagonal uses both multipliers, a neighbor only the first.
  always_comb begin
    mag_b = '0;
    unique case (ent_r)
      ENT_DIAG: begin
        mag_a   = head_cell.mag_dx;
        mag_b   = head_cell.mag_dy;
        h_a     = spacing_y;
        col_sel = head_cell.row;
        ent_nxt = ENT_XP;
      end
      ENT_XP: begin
        mag_a   = head_cell.mag_xp;
        h_a     = spacing_y;
        col_sel = head_cell.col_xp;
        ent_nxt = ENT_XM;
      end
      ENT_XM: begin
        mag_a   = head_cell.mag_xm;
        h_a     = spacing_y;
        col_sel = head_cell.col_xm;
        ent_nxt = ENT_YP;
      end
      ENT_YP: begin
        mag_a   = head_cell.mag_yp;
        h_a     = spacing_x;
        col_sel = head_cell.col_yp;
        ent_nxt = ENT_YN;
      end
      ENT_YN: begin
        mag_a   = head_cell.mag_yn;
        h_a     = spacing_x;
        col_sel = head_cell.col_yn;
        ent_nxt = ENT_DIAG;
      end
      default: begin
        mag_a   = '0;
        h_a     = '0;
        col_sel = '0;
        ent_nxt = ENT_DIAG;
      end
    endcase
    prod_a = PW'(mag_a) * PW'(h_a);
    prod_b = PW'(mag_b) * PW'(spacing_x);
  end

  // Round half up to Q32.16, combine, negate neighbors and saturate to 48 bits.
  always_comb begin
    rnd_a  = prod_a_r + HALF;
    rnd_b  = prod_b_r + HALF;
    sum_ab = {1'b0, rnd_a[PW-1:usw_pkg::FRAC_W]} + {1'b0, rnd_b[PW-1:usw_pkg::FRAC_W]};
    val    = s1_neg_r ? -$signed({1'b0, sum_ab}) : $signed({1'b0, sum_ab});
    priority if (val > SAT_HI) coeff_sat = SAT_HI[KW-1:0];
    else if (val < SAT_LO)     coeff_sat = SAT_LO[KW-1:0];
    else                       coeff_sat = val[KW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r   <= ENT_DIAG;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (issue)   ent_r   <= ent_nxt;
      if (s1_load) s1_v_r  <= !q_stat.empty;
      if (out_adv) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_a_r  <= prod_a;
      prod_b_r  <= prod_b;
      s1_neg_r  <= (ent_r != ENT_DIAG);
      s1_last_r <= (ent_r == ENT_YN);
      s1_row_r  <= head_cell.row;
      s1_col_r  <= col_sel;
    end
    if (out_adv && s1_v_r) begin
      out_row_r   <= s1_row_r;
      out_col_r   <= s1_col_r;
      out_coeff_r <= coeff_sat;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.row_index   = out_row_r;
  assign out_chan.col_index   = out_col_r;
  assign out_chan.coeff_value = out_coeff_r;
  assign out_chan.last_entry  = out_last_r;

endmodule

`default_nettype wire

@@ rtl/upwind_stencil_periodic_2d.sv @@
// A cell's five entries pass in order through the queue, the product stage and the output
// register: the diagonal first, then the x+, x-, y+ and y- neighbors.
// The single result channel carries one entry per cycle while it is not stalled by
// back-pressure; a two-deep queue lets input beats arrive while entries drain.
// Reset (rst_n low at a clock edge) empties the queue and pipeline, zeroes the cell
// counters and loads width 256, height 256 and both spacings 1.0.
`timescale 1ns / 1ps
`default_nettype none

module upwind_stencil_periodic_2d (
  input  wire logic  clk,
  input  wire logic  rst_n,
  usw_in_if.sink     in_chan,
  usw_out_if.source  out_chan,
  usw_cfg_if.sink    cfg_chan
);

  logic [usw_pkg::DIM_W-1:0]   grid_width_r, grid_height_r;
  logic [usw_pkg::SPACE_W-1:0] spacing_x_r, spacing_y_r;

  usw_pkg::usw_qstat_t q_stat;
  usw_pkg::usw_cell_t  push_cell, head_cell;
  logic                push, pop;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= usw_pkg::DIM_RESET;
      grid_height_r <= usw_pkg::DIM_RESET;
      spacing_x_r   <= usw_pkg::SPACE_RESET;
      spacing_y_r   <= usw_pkg::SPACE_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        usw_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_chan.data[usw_pkg::DIM_W-1:0];
        usw_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_chan.data[usw_pkg::DIM_W-1:0];
        usw_pkg::REG_SPACING_X:   spacing_x_r   <= cfg_chan.data[usw_pkg::SPACE_W-1:0];
        usw_pkg::REG_SPACING_Y:   spacing_y_r   <= cfg_chan.data[usw_pkg::SPACE_W-1:0];
        default: ;
      endcase
    end
  end

  usw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .q_stat      (q_stat),
    .push        (push),
    .push_cell   (push_cell)
  );

  usw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cell (push_cell),
    .pop       (pop),
    .head_cell (head_cell),
    .q_stat    (q_stat)
  );

  usw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cell (head_cell),
    .q_stat    (q_stat),
    .spacing_x (spacing_x_r),
    .spacing_y (spacing_y_r),
    .pop       (pop),
    .out_chan  (out_chan)
  );

`ifndef SYNTHESIS
  a_queue_status_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !q_stat.empty)
    else $error("accepted cell did not reach the queue");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

@@ dv/upwind_stencil_periodic_2d_tb.sv @@
`timescale 1ns / 1ps

module upwind_stencil_periodic_2d_tb;
  import usw_pkg::*;

  localparam int CELL_ENTRIES  = 5;
  localparam int ENT_DIAG      = 0;
  localparam int ENT_XP        = 1;
  localparam int ENT_XM        = 2;
  localparam int ENT_YP        = 3;
  localparam int ENT_YM        = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 200;
  localparam int SEGMENTS      = 3;
  localparam int SEG_CELLS     = 39;
  localparam int LIMIT_CYCLES  = 400000;

  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = REG_SPACING_Y + 1;
  localparam logic [CFG_IDX_W-1:0] LAST_REG_IDX     = '1;

  localparam logic signed [FLUX_W-1:0]  ONE       = 32'sh0001_0000;
  localparam logic signed [FLUX_W-1:0]  NEG_ONE   = -ONE;
  localparam logic signed [FLUX_W-1:0]  F_MIN     = 32'sh8000_0000;
  localparam logic signed [FLUX_W-1:0]  F_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [COEFF_W-1:0] C_ONE     = 48'sh0000_0001_0000;
  localparam logic signed [COEFF_W-1:0] C_NEG_ONE = -C_ONE;
  localparam logic signed [COEFF_W-1:0] C_MAX     = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0]        SAT_HI    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0]        SAT_LO    = -SAT_HI - 1;

  typedef struct packed {
    logic signed [FLUX_W-1:0] xp;
    logic signed [FLUX_W-1:0] yp;
    logic signed [FLUX_W-1:0] xm;
    logic signed [FLUX_W-1:0] ym;
  } faces_t;

  typedef struct packed {
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [COEFF_W-1:0] coeff;
    logic                      last;
  } entry_t;

  typedef enum logic {ROW_CELL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [CFG_IDX_W-1:0]               reg_idx;
    logic [CFG_DATA_W-1:0]              reg_data;
    faces_t                             faces;
    logic                               typed;
    logic [CELL_ENTRIES-1:0][COEFF_W-1:0] coeffs;
  } dir_row_t;

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic dir_row_t cell_row(input logic signed [FLUX_W-1:0] xp, yp, xm, ym);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CELL;
    r.faces.xp = xp;
    r.faces.yp = yp;
    r.faces.xm = xm;
    r.faces.ym = ym;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic signed [FLUX_W-1:0] xp, yp, xm, ym,
                                         input logic signed [COEFF_W-1:0] c_dg, c_xp, c_xm,
                                         input logic signed [COEFF_W-1:0] c_yp, c_ym);
    dir_row_t r;
    r = cell_row(xp, yp, xm, ym);
    r.typed = 1'b1;
    r.coeffs[ENT_DIAG] = c_dg;
    r.coeffs[ENT_XP] = c_xp;
    r.coeffs[ENT_XM] = c_xm;
    r.coeffs[ENT_YP] = c_yp;
    r.coeffs[ENT_YM] = c_ym;
    return r;
  endfunction

  // Rows with typed coefficients are read off at a glance: unit spacing after reset,
  // the saturated diagonal at full spacing, and all zeros at zero spacing.
  localparam int DIR_ROWS = 35;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    typed_row(ONE, 0, 0, 0, C_ONE, 0, 0, 0, 0),
    typed_row(NEG_ONE, 0, 0, 0, 0, C_NEG_ONE, 0, 0, 0),
    typed_row(0, 0, ONE, 0, 0, 0, C_NEG_ONE, 0, 0),
    typed_row(0, 0, NEG_ONE, 0, C_ONE, 0, 0, 0, 0),
    typed_row(0, ONE, 0, 0, C_ONE, 0, 0, 0, 0),
    typed_row(0, NEG_ONE, 0, 0, 0, 0, 0, C_NEG_ONE, 0),
    typed_row(0, 0, 0, ONE, 0, 0, 0, 0, C_NEG_ONE),
    typed_row(0, 0, 0, NEG_ONE, C_ONE, 0, 0, 0, 0),
    typed_row(0, 0, 0, 0, 0, 0, 0, 0, 0),
    cell_row(F_MIN, F_MIN, F_MIN, F_MIN),
    cell_row(F_MAX, F_MAX, F_MAX, F_MAX),
    cfg_row(REG_SPACING_X, '1),
    cfg_row(REG_SPACING_Y, '1),
    typed_row(F_MAX, F_MAX, F_MIN, F_MIN, C_MAX, 0, 0, 0, 0),
    cell_row(F_MIN, F_MIN, F_MAX, F_MAX),
    cfg_row(REG_GRID_WIDTH, 0),
    cell_row(ONE, NEG_ONE, F_MAX, F_MIN),
    cfg_row(REG_GRID_HEIGHT, 1),
    cell_row(32'sh0123_4567, -32'sh0765_4321, 32'sh0000_0001, -32'sh0000_0001),
    cell_row(-32'sh0000_8000, 32'sh0000_8000, -32'sh0002_0000, 32'sh0003_0000),
    cell_row(32'sh7654_3210, 32'sh0fed_cba9, -32'sh1234_5678, 32'sh0000_0100),
    cfg_row(REG_GRID_WIDTH, '1),
    cell_row(F_MAX, 0, F_MIN, 0),
    cfg_row(REG_GRID_HEIGHT, 257),
    cell_row(0, F_MAX, 0, F_MIN),
    cfg_row(FIRST_UNUSED_REG, 3),
    cfg_row(LAST_REG_IDX, 2),
    cell_row(ONE, ONE, ONE, ONE),
    cfg_row(REG_SPACING_X, 0),
    cfg_row(REG_SPACING_Y, 0),
    typed_row(F_MAX, F_MIN, F_MIN, F_MAX, 0, 0, 0, 0, 0),
    cfg_row(REG_SPACING_X, 32'h0001_0000),
    cfg_row(REG_SPACING_Y, 32'h0001_8000),
    cell_row(32'sh0000_0001, 32'sh0000_8000, -32'sh0000_0001, 32'sh0001_8000),
    cell_row(-32'sh0000_0001, -32'sh0000_8001, 32'sh0000_0003, -32'sh0001_7FFF)
  };

  logic clk = 1'b0;
  logic rst_n;

  usw_in_if  in_if ();
  usw_out_if out_if ();
  usw_cfg_if cfg_if ();

  upwind_stencil_periodic_2d u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers and the raster position.
  logic [DIM_W-1:0]   grid_w_reg;
  logic [DIM_W-1:0]   grid_h_reg;
  logic [SPACE_W-1:0] space_x_reg;
  logic [SPACE_W-1:0] space_y_reg;
  int unsigned        pos_x;
  int unsigned        pos_y;

  entry_t stencil_q [$];
  int     mismatches = 0;
  int     src_idle_pct = 0;
  int     sink_idle_pct = 0;
  int     hold_asked = 0;
  int     cycle_count;

  function automatic logic [FLUX_W:0] pos_mag(input logic signed [FLUX_W-1:0] g);
    return (g > 0) ? {1'b0, g} : '0;
  endfunction

  function automatic logic [FLUX_W:0] neg_mag(input logic signed [FLUX_W-1:0] g);
    logic signed [FLUX_W:0] g_ext;
    g_ext = g;
    return (g < 0) ? (FLUX_W + 1)'(-g_ext) : '0;
  endfunction

  // Exact Q33.32 product, rounded half up into Q33.16.
  function automatic logic [48:0] face_term(input logic [FLUX_W:0] mag,
                                            input logic [SPACE_W-1:0] h);
    logic [64:0] prod;
    prod = {32'b0, mag} * {33'b0, h} + 65'h8000;
    return prod[64:16];
  endfunction

  function automatic logic signed [COEFF_W-1:0] sat_coeff(input logic signed [63:0] v);
    if (v > SAT_HI) return C_MAX;
    if (v < SAT_LO) return -C_MAX - 1;
    return COEFF_W'(v);
  endfunction

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void stencil_entries(input faces_t f, output entry_t ents [CELL_ENTRIES]);
    int unsigned w, h, x, y, xp, xn, yp, yn, k;
    int unsigned cols [CELL_ENTRIES];
    logic signed [63:0] vals [CELL_ENTRIES];
    w = clamp_dim(grid_w_reg);
    h = clamp_dim(grid_h_reg);
    // A grid shrunk under the running position restarts that coordinate at zero.
    if (pos_x >= w) pos_x = 0;
    if (pos_y >= h) pos_y = 0;
    x = pos_x;
    y = pos_y;
    xp = (x == w - 1) ? 0 : x + 1;
    xn = (x == 0) ? w - 1 : x - 1;
    yp = (y == h - 1) ? 0 : y + 1;
    yn = (y == 0) ? h - 1 : y - 1;
    k = y * w + x;
    cols[ENT_DIAG] = k;
    cols[ENT_XP] = y * w + xp;
    cols[ENT_XM] = y * w + xn;
    cols[ENT_YP] = yp * w + x;
    cols[ENT_YM] = yn * w + x;
    vals[ENT_DIAG] = 64'(face_term(pos_mag(f.xp) + neg_mag(f.xm), space_y_reg))
                   + 64'(face_term(pos_mag(f.yp) + neg_mag(f.ym), space_x_reg));
    vals[ENT_XP] = -64'(face_term(neg_mag(f.xp), space_y_reg));
    vals[ENT_XM] = -64'(face_term(pos_mag(f.xm), space_y_reg));
    vals[ENT_YP] = -64'(face_term(neg_mag(f.yp), space_x_reg));
    vals[ENT_YM] = -64'(face_term(pos_mag(f.ym), space_x_reg));
    for (int i = 0; i < CELL_ENTRIES; i++) begin
      ents[i].row = IDX_W'(k);
      ents[i].col = IDX_W'(cols[i]);
      ents[i].coeff = sat_coeff(vals[i]);
      ents[i].last = (i == CELL_ENTRIES - 1);
    end
    if (x + 1 >= w) begin
      pos_x = 0;
      pos_y = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      pos_x = x + 1;
    end
  endfunction

  // Waits until every expected entry has come out, then lets the pipeline drain.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (stencil_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:  grid_w_reg = data[DIM_W-1:0];
      REG_GRID_HEIGHT: grid_h_reg = data[DIM_W-1:0];
      REG_SPACING_X:   space_x_reg = data;
      REG_SPACING_Y:   space_y_reg = data;
      default: ;
    endcase
  endtask

  task automatic send_cell(input faces_t f, input logic typed,
                           input logic [CELL_ENTRIES-1:0][COEFF_W-1:0] coeffs);
    entry_t ents [CELL_ENTRIES];
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.flux_x_plus <= f.xp;
    in_if.flux_y_plus <= f.yp;
    in_if.flux_x_minus <= f.xm;
    in_if.flux_y_minus <= f.ym;
    do @(posedge clk); while (!in_if.ready);
    stencil_entries(f, ents);
    for (int i = 0; i < CELL_ENTRIES; i++) begin
      if (typed) ents[i].coeff = coeffs[i];
      stencil_q.push_back(ents[i]);
    end
  endtask

  function automatic logic signed [FLUX_W-1:0] rand_flux();
    case ($urandom_range(7))
      0: return 0;
      1: return F_MIN;
      2: return F_MAX;
      3: return FLUX_W'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_dim_word();
    logic [DIM_W-1:0] dim;
    case ($urandom_range(9))
      0: dim = 0;
      1: dim = 1;
      2: dim = MAX_DIM;
      3: dim = '1;
      4: dim = $urandom_range(300, 9);
      default: dim = $urandom_range(6, MIN_DIM);
    endcase
    // The upper bits of the write data are not part of the register.
    return {$urandom() >> DIM_W, dim};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_spacing();
    case ($urandom_range(5))
      0: return 0;
      1: return '1;
      2: return SPACE_RESET;
      3: return $urandom_range(32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_GRID_WIDTH, rand_dim_word());
    write_reg(REG_GRID_HEIGHT, rand_dim_word());
    write_reg(REG_SPACING_X, rand_spacing());
    write_reg(REG_SPACING_Y, rand_spacing());
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(LAST_REG_IDX, FIRST_UNUSED_REG)), $urandom());
  endtask

  // Result side: random back-pressure, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    entry_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (stencil_q.size() == 0) begin
        $error("unexpected beat: row_index %0d col_index %0d", out_if.row_index,
               out_if.col_index);
        mismatches++;
      end else begin
        want = stencil_q.pop_front();
        if (out_if.row_index !== want.row) begin
          $error("row_index: expected %0d, got %0d", want.row, out_if.row_index);
          mismatches++;
        end
        if (out_if.col_index !== want.col) begin
          $error("col_index: expected %0d, got %0d", want.col, out_if.col_index);
          mismatches++;
        end
        if (out_if.coeff_value !== want.coeff) begin
          $error("coeff_value: expected %0d, got %0d", want.coeff, out_if.coeff_value);
          mismatches++;
        end
        if (out_if.last_entry !== want.last) begin
          $error("last_entry: expected %0b, got %0b", want.last, out_if.last_entry);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.flux_x_plus <= '0;
    in_if.flux_y_plus <= '0;
    in_if.flux_x_minus <= '0;
    in_if.flux_y_minus <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    grid_w_reg = DIM_RESET;
    grid_h_reg = DIM_RESET;
    space_x_reg = SPACE_RESET;
    space_y_reg = SPACE_RESET;
    pos_x = 0;
    pos_y = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 20;
    sink_idle_pct = 20;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].kind == ROW_CFG)
        write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].reg_data);
      else
        send_cell(DIR_TAB[i].faces, DIR_TAB[i].typed, DIR_TAB[i].coeffs);
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle_pct = 30;
          sink_idle_pct = 84;
        end
        1: begin
          src_idle_pct = 84;
          sink_idle_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < SEGMENTS; s++) begin
        random_config();
        // With no idling otherwise, a long result stall makes the queue fill up
        // and pushes back on the input beats.
        if (p == 2 && s == 1) hold_asked++;
        repeat (SEG_CELLS) send_cell('{rand_flux(), rand_flux(), rand_flux(), rand_flux()},
                                     1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
